@@ sv/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is high
`define SSF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ssf assertion failed");

// clocked property that also holds across reset
`define SSF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ssf assertion failed");

`endif

@@ sv/ssf_pkg.sv @@
// shared constants, types and helpers of the state-space filter
// no dependencies
package ssf_pkg;

  localparam int STATE_DIM_DEF = 4;
  localparam int DATA_W        = 32;
  localparam int COEF_W        = 16;
  localparam int PROD_W        = DATA_W + COEF_W;
  localparam int IDX_W         = 5;
  localparam int OPC_W         = 2;
  localparam int FRAC_SHIFT    = 12;

  localparam logic [OPC_W-1:0] OP_SAMPLE  = 2'd0;
  localparam logic [OPC_W-1:0] OP_COEF    = 2'd1;
  localparam logic [OPC_W-1:0] OP_INIT    = 2'd2;
  localparam logic [OPC_W-1:0] OP_RESTORE = 2'd3;

  // per-step control broadcast to every cell
  typedef struct packed {
    logic start;   // clear accumulator, load start column
    logic mac;     // issue one multiply this cycle
    logic use_u;   // operand is the input sample, coefficient is B or D
  } ssf_ctrl_t;

  // coefficient write broadcast to every cell
  typedef struct packed {
    logic                     en;
    logic [IDX_W-1:0]         index;
    logic signed [COEF_W-1:0] value;
  } ssf_cwr_t;

  // clamp a Q20.12 write value into the Q4.12 coefficient range
  function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [DATA_W-1:0] v);
    logic signed [COEF_W-1:0] r;
    if (v > DATA_W'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -DATA_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[COEF_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ sv/state_space_siso_step.sv @@
// top level of the single-input single-output state-space filter
// depends on ssf_pkg and ssf_cell
//
// usage:
//   input channel (in_valid/in_ready) takes one item per handshake: opcode
//   selects sample, coefficient write, initial-state write or state restore
//   output channel (out_valid/out_ready) gives y and the overflow flag, one
//   item for each sample and none for the other opcodes
//   a row of STATE_DIM+1 cells works in parallel: one cell per state row plus
//   one for the output row; the state vector rotates through the ring of
//   state registers so each cell sees one state entry per cycle
//   a sample passes through an accept cycle, STATE_DIM+1 multiply steps
//   (state entries, then u), an accumulate drain and a rounding/write-back
//   cycle; its result is registered at write-back and the next item is
//   taken in the cycle after that
//   coefficient, initial-state and restore items are written at the
//   accepting edge and leave the block ready for the next item
//   the output register frees the input side: a new item is accepted while
//   an earlier result waits; a finished sample waits in its last cycle only
//   if the output register is still full
//   reset clears coefficients, state, initial state and the output valid
module state_space_siso_step #(
  parameter int STATE_DIM = ssf_pkg::STATE_DIM_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [ssf_pkg::OPC_W-1:0]               opcode,
  input  logic signed [ssf_pkg::DATA_W-1:0]       sample,
  input  logic [ssf_pkg::IDX_W-1:0]               entry_index,
  input  logic signed [ssf_pkg::DATA_W-1:0]       entry_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [ssf_pkg::DATA_W-1:0]       filter_output,
  output logic                                    overflow
);

  localparam int SLOT_W = $clog2(STATE_DIM + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t                              state;
  state_t                              state_next;
  logic [SLOT_W-1:0]                   step;
  logic signed [ssf_pkg::DATA_W-1:0]   u_reg;
  logic signed [ssf_pkg::DATA_W-1:0]   xv   [STATE_DIM];   // state ring
  logic signed [ssf_pkg::DATA_W-1:0]   init [STATE_DIM];

  logic                                in_fire;
  logic                                fin_fire;
  logic                                last_step;
  ssf_pkg::ssf_ctrl_t                  ctrl;
  ssf_pkg::ssf_cwr_t                   cwr;

  logic signed [ssf_pkg::DATA_W-1:0]   row_res [STATE_DIM];
  logic        [STATE_DIM-1:0]         row_sat;
  logic signed [ssf_pkg::DATA_W-1:0]   y_res;
  logic                                y_sat;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign last_step = (step == SLOT_W'(STATE_DIM));
  // write-back waits only while the output register holds a result that is not being taken
  assign fin_fire  = (state == S_FIN) && (!out_valid || out_ready);

  // cell control: start on sample accept, one multiply per MAC step
  assign ctrl.start = in_fire && (opcode == ssf_pkg::OP_SAMPLE);
  assign ctrl.mac   = (state == S_MAC);
  assign ctrl.use_u = (state == S_MAC) && last_step;

  assign cwr.en    = in_fire && (opcode == ssf_pkg::OP_COEF);
  assign cwr.index = entry_index;
  assign cwr.value = ssf_pkg::sat_coef(entry_value);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire && (opcode == ssf_pkg::OP_SAMPLE)) begin
          state_next = S_MAC;
        end
      end
      S_MAC: begin
        if (last_step) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (fin_fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (ctrl.start) begin
        step <= '0;
      end else if (state == S_MAC && !last_step) begin
        step <= step + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      u_reg <= sample;
    end
  end

  // ring of state registers and the initial-state row
  for (genvar i = 0; i < STATE_DIM; i++) begin : g_ring
    always_ff @(posedge clk) begin
      if (rst) begin
        xv[i]   <= '0;
        init[i] <= '0;
      end else begin
        if (in_fire && (opcode == ssf_pkg::OP_INIT) &&
            (32'(entry_index) == 32'(i))) begin
          init[i] <= entry_value;
        end
        if (in_fire && (opcode == ssf_pkg::OP_RESTORE)) begin
          xv[i] <= init[i];
        end else if (state == S_MAC && !last_step) begin
          // after STATE_DIM shifts the ring is back in place
          xv[i] <= xv[(i + 1) % STATE_DIM];
        end else if (fin_fire) begin
          xv[i] <= row_res[i];
        end
      end
    end

    ssf_cell #(
      .STATE_DIM (STATE_DIM),
      .FIRST_IDX (i * STATE_DIM),
      .EXTRA_IDX (STATE_DIM * STATE_DIM + i),
      .START_COL (i)
    ) u_row (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .cwr  (cwr),
      .opnd (ctrl.use_u ? u_reg : xv[i]),
      .res  (row_res[i]),
      .sat  (row_sat[i])
    );
  end

  // output row: C against the entry passing ring slot zero, then D against u
  ssf_cell #(
    .STATE_DIM (STATE_DIM),
    .FIRST_IDX (STATE_DIM * STATE_DIM + STATE_DIM),
    .EXTRA_IDX (STATE_DIM * STATE_DIM + 2 * STATE_DIM),
    .START_COL (0)
  ) u_out_row (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .cwr  (cwr),
    .opnd (ctrl.use_u ? u_reg : xv[0]),
    .res  (y_res),
    .sat  (y_sat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      filter_output <= y_res;
      overflow      <= y_sat || (|row_sat);
    end
  end

endmodule

@@ sv/ssf_cell.sv @@
// one row cell: coefficient row, multiplier, accumulator and rounding
// depends on ssf_pkg
module ssf_cell #(
  parameter int STATE_DIM = ssf_pkg::STATE_DIM_DEF,
  parameter int FIRST_IDX = 0,
  parameter int EXTRA_IDX = 0,
  parameter int START_COL = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  ssf_pkg::ssf_ctrl_t                ctrl,
  input  ssf_pkg::ssf_cwr_t                 cwr,
  input  logic signed [ssf_pkg::DATA_W-1:0] opnd,
  output logic signed [ssf_pkg::DATA_W-1:0] res,
  output logic                              sat
);

  localparam int SLOT_W = $clog2(STATE_DIM + 1);
  localparam int ACC_W  = ssf_pkg::PROD_W + $clog2(STATE_DIM + 2);
  localparam int TOP_LO = ssf_pkg::FRAC_SHIFT + ssf_pkg::DATA_W - 1;

  logic signed [ssf_pkg::COEF_W-1:0] coef [STATE_DIM+1];
  logic        [SLOT_W-1:0]          col;
  logic signed [ssf_pkg::PROD_W-1:0] prod;
  logic                              prod_v;
  logic signed [ACC_W-1:0]           acc;

  logic        [31:0]                idx_i;
  logic                              hit_row;
  logic                              hit_extra;
  logic        [SLOT_W-1:0]          wr_slot;
  logic        [SLOT_W-1:0]          rd_slot;
  logic signed [ssf_pkg::COEF_W-1:0] coef_sel;
  logic signed [ACC_W-1:0]           rnd;
  logic        [ACC_W-TOP_LO-1:0]    hi;

  // which slot of this row a coefficient write lands in
  assign idx_i     = 32'(cwr.index);
  assign hit_row   = (idx_i >= 32'(FIRST_IDX)) && (idx_i < 32'(FIRST_IDX + STATE_DIM));
  assign hit_extra = (idx_i == 32'(EXTRA_IDX));
  assign wr_slot   = hit_extra ? SLOT_W'(STATE_DIM) : SLOT_W'(idx_i - 32'(FIRST_IDX));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= STATE_DIM; s++) begin
        coef[s] <= '0;
      end
    end else if (cwr.en && (hit_row || hit_extra)) begin
      coef[wr_slot] <= cwr.value;
    end
  end

  assign rd_slot  = ctrl.use_u ? SLOT_W'(STATE_DIM) : col;
  assign coef_sel = coef[rd_slot];

  // column walks with the rotating state, starting at this row's own column
  always_ff @(posedge clk) begin
    if (rst) begin
      col    <= '0;
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctrl.mac;
      if (ctrl.start) begin
        col <= SLOT_W'(START_COL);
      end else if (ctrl.mac) begin
        col <= (col == SLOT_W'(STATE_DIM - 1)) ? '0 : col + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mac) begin
      prod <= ssf_pkg::PROD_W'(coef_sel) * ssf_pkg::PROD_W'(opnd);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // round half up, drop fraction bits, clamp to 32 bits
  assign rnd = acc + ACC_W'(1 << (ssf_pkg::FRAC_SHIFT - 1));
  assign hi  = rnd[ACC_W-1:TOP_LO];
  assign sat = !((&hi) || !(|hi));

  always_comb begin
    if (!sat) begin
      res = rnd[TOP_LO:ssf_pkg::FRAC_SHIFT];
    end else if (rnd[ACC_W-1]) begin
      res = {1'b1, {(ssf_pkg::DATA_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(ssf_pkg::DATA_W-1){1'b1}}};
    end
  end

endmodule

@@ sv/ssf_checker.sv @@
// port-level checker for the state-space filter, bound to the top level
// depends on ssf_pkg and assert_macros.svh
`include "assert_macros.svh"

module ssf_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [ssf_pkg::OPC_W-1:0]           opcode,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [ssf_pkg::DATA_W-1:0]   filter_output,
  input logic                                overflow
);

  // reset leaves no result pending
  `SSF_ASSERT_ALWAYS(a_rst_clears_out, clk, rst |=> !out_valid)

  // a stalled result stays and keeps its value
  `SSF_ASSERT(a_out_hold, clk, rst,
    out_valid && !out_ready |=> out_valid && $stable(filter_output) && $stable(overflow))

  // a sample keeps the block busy for the following cycle
  `SSF_ASSERT(a_sample_busy, clk, rst,
    in_valid && in_ready && opcode == ssf_pkg::OP_SAMPLE |=> !in_ready)

  // non-sample items never raise a result in the next cycle
  `SSF_ASSERT(a_cfg_no_result, clk, rst,
    in_valid && in_ready && opcode != ssf_pkg::OP_SAMPLE |=> !$rose(out_valid))

  // a new result only appears while the input side is idle
  `SSF_ASSERT(a_result_when_idle, clk, rst, $rose(out_valid) |-> in_ready)

endmodule

bind state_space_siso_step ssf_checker u_ssf_checker (.*);

@@ sim/ssf_monitor.sv @@
// watches both channels of the state-space filter, predicts every sample result and compares
// depends on ssf_pkg for widths and opcodes
module ssf_monitor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [ssf_pkg::OPC_W-1:0]         opcode,
  input  logic signed [ssf_pkg::DATA_W-1:0] sample,
  input  logic [ssf_pkg::IDX_W-1:0]         entry_index,
  input  logic signed [ssf_pkg::DATA_W-1:0] entry_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [ssf_pkg::DATA_W-1:0] filter_output,
  input  logic                              overflow,
  output int                                errors,
  output int                                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ssf_pkg::*;

  localparam int N      = STATE_DIM_DEF;
  localparam int NCOEF  = N * N + 2 * N + 1;
  localparam int B_BASE = N * N;
  localparam int C_BASE = B_BASE + N;
  localparam int D_IDX  = C_BASE + N;

  typedef struct packed {
    logic signed [DATA_W-1:0] y;
    logic                     ovf;
  } filter_result_t;

  logic signed [COEF_W-1:0] coef   [NCOEF];
  logic signed [DATA_W-1:0] x_now  [N];
  logic signed [DATA_W-1:0] x_init [N];
  filter_result_t           expected_outputs [$];

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // round half up, drop the fraction bits, clamp to 32 bits
  function automatic logic signed [DATA_W-1:0] scale_sat(input longint acc, inout bit sat);
    longint q;
    q = (acc + 64'sd2048) >>> FRAC_SHIFT;
    if (q > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (q < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return q[DATA_W-1:0];
  endfunction

  // y from the old state, then every new state entry from the old state
  task automatic filter_step(input logic signed [DATA_W-1:0] u_in, output filter_result_t r);
    longint                   u;
    longint                   acc;
    bit                       sat;
    logic signed [DATA_W-1:0] nxt [N];
    u   = u_in;
    sat = 1'b0;
    acc = longint'(coef[D_IDX]) * u;
    for (int i = 0; i < N; i++) acc += longint'(coef[C_BASE + i]) * longint'(x_now[i]);
    r.y = scale_sat(acc, sat);
    for (int i = 0; i < N; i++) begin
      acc = longint'(coef[B_BASE + i]) * u;
      for (int j = 0; j < N; j++) acc += longint'(coef[i * N + j]) * longint'(x_now[j]);
      nxt[i] = scale_sat(acc, sat);
    end
    x_now = nxt;
    r.ovf = sat;
  endtask

  always @(posedge clk) begin
    filter_result_t want;
    if (rst) begin
      for (int i = 0; i < NCOEF; i++) coef[i] = '0;
      for (int i = 0; i < N; i++) begin
        x_now[i]  = '0;
        x_init[i] = '0;
      end
      expected_outputs.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          report($sformatf("result y=%0d with no sample waiting", filter_output));
        end else begin
          want = expected_outputs.pop_front();
          if (filter_output !== want.y)
            report($sformatf("filter_output %0d, want %0d", filter_output, want.y));
          if (overflow !== want.ovf)
            report($sformatf("overflow %0b, want %0b (y=%0d)", overflow, want.ovf, want.y));
        end
      end
      if (in_valid && in_ready) begin
        case (opcode)
          OP_COEF: begin
            if (entry_index < NCOEF) begin
              if (entry_value > 32767)       coef[entry_index] = 16'sh7fff;
              else if (entry_value < -32768) coef[entry_index] = 16'sh8000;
              else                           coef[entry_index] = entry_value[COEF_W-1:0];
            end
          end
          OP_INIT: begin
            if (entry_index < N) x_init[entry_index] = entry_value;
          end
          OP_RESTORE: begin
            x_now = x_init;
          end
          default: begin
            filter_step(sample, want);
            expected_outputs.insert(expected_outputs.size(), want);
          end
        endcase
      end
      pending <= expected_outputs.size();
    end
  end

endmodule

@@ sim/tb.sv @@
// stimulus and verdict for the state-space filter: directed corner items, then random
// phases under varying idle and stall rates; depends on ssf_pkg, the block and ssf_monitor
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssf_pkg::*;

  localparam int N      = STATE_DIM_DEF;
  localparam int NCOEF  = N * N + 2 * N + 1;
  localparam int B_BASE = N * N;
  localparam int C_BASE = B_BASE + N;
  localparam int D_IDX  = C_BASE + N;

  logic                     clk;
  logic                     rst         = 1'b1;
  logic                     in_valid    = 1'b0;
  logic                     in_ready;
  logic [OPC_W-1:0]         opcode      = OP_SAMPLE;
  logic signed [DATA_W-1:0] sample      = '0;
  logic [IDX_W-1:0]         entry_index = '0;
  logic signed [DATA_W-1:0] entry_value = '0;
  logic                     out_valid;
  logic                     out_ready   = 1'b0;
  logic signed [DATA_W-1:0] filter_output;
  logic                     overflow;

  int n_errors;
  int n_pending;
  // chance in percent that the sender idles / the receiver stalls on a cycle
  int idle_pct  = 0;
  int stall_pct = 0;

  state_space_siso_step u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .sample        (sample),
    .entry_index   (entry_index),
    .entry_value   (entry_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .filter_output (filter_output),
    .overflow      (overflow)
  );

  ssf_monitor u_monitor (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .sample        (sample),
    .entry_index   (entry_index),
    .entry_value   (entry_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .filter_output (filter_output),
    .overflow      (overflow),
    .errors        (n_errors),
    .pending       (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // one item through the input channel; valid only drops when a gap is drawn,
  // so a back-to-back item never sees valid lowered and raised in one step
  task automatic send(input logic [OPC_W-1:0] op, input logic signed [DATA_W-1:0] smp,
                      input logic [IDX_W-1:0] idx, input logic signed [DATA_W-1:0] val);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    sample      <= smp;
    entry_index <= idx;
    entry_value <= val;
    // in_ready here is the value seen at the edge, before any update
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender off until the monitor has seen every expected result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  // mostly gentle Q4.12 gains so the state stays in range, some raw words that clamp
  function automatic logic signed [DATA_W-1:0] coef_word();
    if ($urandom_range(99) < 85) return int'($urandom_range(4095)) - 2048;
    return $urandom;
  endfunction

  // samples within +-0x20000 most of the time, full range otherwise
  function automatic logic signed [DATA_W-1:0] sample_word();
    if ($urandom_range(99) < 70) return int'($urandom_range(32'h0003_ffff)) - 32'sh0002_0000;
    return $urandom;
  endfunction

  task automatic directed_items();
    // clamping of coefficient writes at both ends
    send(OP_COEF, 0, IDX_W'(D_IDX), 40000);
    send(OP_COEF, 0, IDX_W'(C_BASE), -40000);
    // coefficient indexes past the store are dropped
    send(OP_COEF, 0, IDX_W'(NCOEF), 32'sh0000_1234);
    send(OP_COEF, 0, IDX_W'(31), -1);
    // initial state at the extremes, plus out-of-range state indexes
    send(OP_INIT, 0, IDX_W'(0), 32'sh7fff_ffff);
    send(OP_INIT, 0, IDX_W'(N - 1), 32'sh8000_0000);
    send(OP_INIT, 0, IDX_W'(N), 5);
    send(OP_INIT, 0, IDX_W'(31), 7);
    // initial-state writes alone leave the running state at zero
    send(OP_SAMPLE, 32'sh7fff_ffff, IDX_W'(0), 0);
    send(OP_RESTORE, 32'sh1234_5678, IDX_W'(31), -1);
    // large gains on extreme state and input drive y into saturation
    send(OP_SAMPLE, 32'sh7fff_ffff, IDX_W'(0), 0);
    send(OP_SAMPLE, 32'sh8000_0000, IDX_W'(31), 32'sh7fff_ffff);
    // unity path through A00, B0, C0 and a half-step D for rounding ties
    send(OP_COEF, 0, IDX_W'(0), 4096);
    send(OP_COEF, 0, IDX_W'(B_BASE), 4096);
    send(OP_COEF, 0, IDX_W'(C_BASE), 4096);
    send(OP_COEF, 0, IDX_W'(D_IDX), 2048);
    send(OP_RESTORE, 0, IDX_W'(0), 0);
    send(OP_SAMPLE, 1, IDX_W'(31), -1);
    send(OP_SAMPLE, -1, IDX_W'(0), 32'sh8000_0000);
    send(OP_SAMPLE, 3, IDX_W'(5), 0);
    send(OP_COEF, 0, IDX_W'(C_BASE + N - 1), 32767);
    send(OP_COEF, 0, IDX_W'(N * N - 1), -32768);
    send(OP_SAMPLE, 0, IDX_W'(0), 0);
  endtask

  // mostly well-formed traffic: program gains, seed the state, restore, run samples;
  // the rest is fully random items, some of which the block drops
  task automatic random_items(input int count);
    int done_n;
    int pick;
    int k;
    logic [OPC_W-1:0] op;
    logic [IDX_W-1:0] idx;
    done_n = 0;
    while (done_n < count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        k = $urandom_range(1, 6);
        repeat (k) send(OP_COEF, $urandom, IDX_W'($urandom_range(NCOEF - 1)), coef_word());
        done_n += k;
      end else if (pick < 14) begin
        send(OP_INIT, $urandom, IDX_W'($urandom_range(N - 1)), sample_word());
        done_n++;
      end else if (pick < 19) begin
        send(OP_RESTORE, $urandom, IDX_W'($urandom), $urandom);
        done_n++;
      end else if (pick < 27) begin
        op  = OPC_W'($urandom);
        idx = IDX_W'($urandom);
        send(op, $urandom, idx, $urandom);
        // dropped writes do not count toward the phase
        if (!((op == OP_COEF && idx >= NCOEF) || (op == OP_INIT && idx >= N))) done_n++;
      end else begin
        send(OP_SAMPLE, sample_word(), IDX_W'($urandom), $urandom);
        done_n++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    directed_items();
    drain();
    // phases: free running, idle sender, stalling receiver, light idling on both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 55; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 9;  stall_pct = 9;  end
      endcase
      random_items(175);
      drain();
    end
    // leave room for any stray result
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/ssf_pkg.sv
sv/ssf_cell.sv
sv/state_space_siso_step.sv
sv/ssf_checker.sv
sim/ssf_monitor.sv
sim/tb.sv
